[design/ofb_pkg.sv]
`default_nettype none
package ofb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FALLBACK_X  = 3'd0,
    CFG_FALLBACK_Y  = 3'd1,
    CFG_FALLBACK_Z  = 3'd2,
    CFG_ZERO_THR    = 3'd3,
    CFG_PARALLEL_THR = 3'd4
  } ofb_cfg_idx_t;

  localparam logic [15:0] FALLBACK_X_RST   = 16'h0000;
  localparam logic [15:0] FALLBACK_Y_RST   = 16'h4000;
  localparam logic [15:0] FALLBACK_Z_RST   = 16'h0000;
  localparam logic [15:0] ZERO_THR_RST     = 16'd1;
  localparam logic [28:0] PARALLEL_THR_RST = 29'd26844;

  typedef logic [2:0][31:0] ofb_vec32_t;
  typedef logic [2:0][15:0] ofb_vec16_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ofb_in_t;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] rgt_x;
    logic signed [15:0] rgt_y;
    logic signed [15:0] rgt_z;
    logic signed [15:0] upv_x;
    logic signed [15:0] upv_y;
    logic signed [15:0] upv_z;
    logic               forward_fell_back;
    logic               right_fell_back;
    logic               used_x_axis;
  } ofb_out_t;

  typedef struct packed {
    ofb_vec16_t fwd;
    logic       ffb;
    logic       usedx;
  } ofb_tag_t;

  function automatic logic [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      return 16'h7fff;
    end else if (v < -34'sd32768) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

[design/ofb_norm.sv]
`default_nettype none
module ofb_norm
  import ofb_pkg::*;
#(
  parameter int RECIP_ITERATIONS = 16,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ofb_vec32_t       in_vec,
  input  logic [TAG_W-1:0] in_tag,
  input  ofb_vec16_t       fallback,
  input  logic [15:0]      zero_thr,
  output logic             out_valid,
  output ofb_vec16_t       out_vec,
  output logic             out_fb,
  output logic [TAG_W-1:0] out_tag
);

  localparam int Q_W    = RECIP_ITERATIONS + 1;
  localparam int PROD_W = 32 + Q_W;
  localparam int SHR    = 17 + RECIP_ITERATIONS;

  // magnitude and sign
  logic             v0;
  logic [TAG_W-1:0] tag0;
  logic [2:0]       neg0;
  ofb_vec32_t       mag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    tag0 <= in_tag;
    for (int i = 0; i < 3; i++) begin
      neg0[i] <= in_vec[i][31];
      mag0[i] <= in_vec[i][31] ? 32'(-in_vec[i]) : in_vec[i];
    end
  end

  // squares
  logic             v1;
  logic [TAG_W-1:0] tag1;
  logic [2:0]       neg1;
  ofb_vec32_t       mag1;
  logic [2:0][63:0] sq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    tag1 <= tag0;
    neg1 <= neg0;
    mag1 <= mag0;
    for (int i = 0; i < 3; i++) begin
      sq1[i] <= {32'b0, mag0[i]} * {32'b0, mag0[i]};
    end
  end

  // square root, one result bit per stage
  logic             qv   [0:32];
  logic [TAG_W-1:0] qtag [0:32];
  logic [2:0]       qneg [0:32];
  ofb_vec32_t       qmag [0:32];
  logic [63:0]      qrem [0:32];
  logic [63:0]      qres [0:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else begin
      qv[0] <= v1;
    end
    qtag[0] <= tag1;
    qneg[0] <= neg1;
    qmag[0] <= mag1;
    qrem[0] <= sq1[0] + sq1[1] + sq1[2];
    qres[0] <= '0;
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (31 - j));
    logic [64:0] trial;
    assign trial = {1'b0, qres[j]} + {1'b0, SQ_BIT};
    always_ff @(posedge clk) begin
      if (rst) begin
        qv[j+1] <= 1'b0;
      end else begin
        qv[j+1] <= qv[j];
      end
      qtag[j+1] <= qtag[j];
      qneg[j+1] <= qneg[j];
      qmag[j+1] <= qmag[j];
      if ({1'b0, qrem[j]} >= trial) begin
        qrem[j+1] <= qrem[j] - trial[63:0];
        qres[j+1] <= (qres[j] >> 1) + SQ_BIT;
      end else begin
        qrem[j+1] <= qrem[j];
        qres[j+1] <= qres[j] >> 1;
      end
    end
  end

  // leading-zero shift of the length, mags follow
  logic             lv   [0:5];
  logic [TAG_W-1:0] ltag [0:5];
  logic [2:0]       lneg [0:5];
  ofb_vec32_t       lmag [0:5];
  logic [31:0]      lm   [0:5];
  logic             lfb  [0:5];
  logic [31:0]      len;

  assign len = qres[32][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else begin
      lv[0] <= qv[32];
    end
    ltag[0] <= qtag[32];
    lneg[0] <= qneg[32];
    lmag[0] <= qmag[32];
    lm[0]   <= len;
    lfb[0]  <= (len == 32'd0) || (len < {16'b0, zero_thr});
  end

  for (genvar k = 0; k < 5; k++) begin : g_lz
    localparam int SH = 16 >> k;
    always_ff @(posedge clk) begin
      if (rst) begin
        lv[k+1] <= 1'b0;
      end else begin
        lv[k+1] <= lv[k];
      end
      ltag[k+1] <= ltag[k];
      lneg[k+1] <= lneg[k];
      lfb[k+1]  <= lfb[k];
      if (lm[k][31 -: SH] == '0) begin
        lm[k+1] <= lm[k] << SH;
        for (int i = 0; i < 3; i++) begin
          lmag[k+1][i] <= lmag[k][i] << SH;
        end
      end else begin
        lm[k+1]   <= lm[k];
        lmag[k+1] <= lmag[k];
      end
    end
  end

  // reciprocal, one quotient bit per stage
  logic             dv   [0:Q_W];
  logic [TAG_W-1:0] dtag [0:Q_W];
  logic [2:0]       dneg [0:Q_W];
  ofb_vec32_t       dmag [0:Q_W];
  logic [31:0]      dm   [0:Q_W];
  logic             dfb  [0:Q_W];
  logic [32:0]      drem [1:Q_W];
  logic [Q_W-1:0]   dq   [1:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= lv[5];
    end
    dtag[0] <= ltag[5];
    dneg[0] <= lneg[5];
    dmag[0] <= lmag[5];
    dm[0]   <= lm[5];
    dfb[0]  <= lfb[5];
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    logic [32:0]    prev_rem;
    logic [Q_W-1:0] prev_q;
    logic [32:0]    cand;
    if (i == 0) begin : g_first
      assign prev_rem = 33'd1 << 30;
      assign prev_q   = '0;
    end else begin : g_next
      assign prev_rem = drem[i];
      assign prev_q   = dq[i];
    end
    assign cand = {prev_rem[31:0], 1'b0};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
      dtag[i+1] <= dtag[i];
      dneg[i+1] <= dneg[i];
      dmag[i+1] <= dmag[i];
      dm[i+1]   <= dm[i];
      dfb[i+1]  <= dfb[i];
      if (cand >= {1'b0, dm[i]}) begin
        drem[i+1] <= cand - {1'b0, dm[i]};
        dq[i+1]   <= {prev_q[Q_W-2:0], 1'b1};
      end else begin
        drem[i+1] <= cand;
        dq[i+1]   <= {prev_q[Q_W-2:0], 1'b0};
      end
    end
  end

  // scale
  logic                   pv;
  logic [TAG_W-1:0]       ptag;
  logic [2:0]             pneg;
  logic                   pfb;
  logic [2:0][PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= dv[Q_W];
    end
    ptag <= dtag[Q_W];
    pneg <= dneg[Q_W];
    pfb  <= dfb[Q_W];
    for (int i = 0; i < 3; i++) begin
      prod[i] <= PROD_W'(dmag[Q_W][i]) * PROD_W'(dq[Q_W]);
    end
  end

  // sign, saturate, fallback
  logic [2:0][16:0] sres;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sres[i] = pneg[i] ? 17'(-{1'b0, prod[i][SHR +: 16]}) : {1'b0, prod[i][SHR +: 16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pv;
    end
    out_tag <= ptag;
    out_fb  <= pfb;
    for (int i = 0; i < 3; i++) begin
      out_vec[i] <= pfb ? fallback[i] : sat16(34'($signed(sres[i])));
    end
  end

endmodule
`default_nettype wire

[design/ofb_rgt.sv]
`default_nettype none
module ofb_rgt
  import ofb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  ofb_vec16_t  fwd,
  input  logic        ffb,
  input  logic [28:0] par_thr,
  output logic        out_valid,
  output ofb_vec32_t  rq,
  output ofb_tag_t    out_tag
);

  logic        v1;
  ofb_vec16_t  f1;
  logic        ffb1;
  logic [31:0] sa;
  logic [31:0] sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    f1   <= fwd;
    ffb1 <= ffb;
    sa   <= 32'($signed(fwd[1]) * $signed(fwd[1]));
    sb   <= 32'($signed(fwd[0]) * $signed(fwd[0]));
  end

  logic [31:0]      dot;
  logic             usedx;
  logic [2:0][16:0] rawr;

  always_comb begin
    dot   = sa + sb;
    usedx = dot < {3'b0, par_thr};
    if (usedx) begin
      rawr[0] = '0;
      rawr[1] = {f1[2][15], f1[2]};
      rawr[2] = 17'(-$signed({f1[1][15], f1[1]}));
    end else begin
      rawr[0] = {f1[1][15], f1[1]};
      rawr[1] = 17'(-$signed({f1[0][15], f1[0]}));
      rawr[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    out_tag.fwd   <= f1;
    out_tag.ffb   <= ffb1;
    out_tag.usedx <= usedx;
    for (int i = 0; i < 3; i++) begin
      rq[i] <= {{13{rawr[i][16]}}, rawr[i], 2'b00};
    end
  end

endmodule
`default_nettype wire

[design/ofb_upv.sv]
`default_nettype none
module ofb_upv
  import ofb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  ofb_vec16_t rgt,
  input  logic       rfb,
  input  ofb_tag_t   tag,
  output logic       done,
  output ofb_out_t   result
);

  logic                    v1;
  ofb_vec16_t              r1;
  logic                    rfb1;
  ofb_tag_t                tag1;
  logic signed [5:0][31:0] p;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    r1   <= rgt;
    rfb1 <= rfb;
    tag1 <= tag;
    p[0] <= 32'($signed(rgt[1]) * $signed(tag.fwd[2]));
    p[1] <= 32'($signed(rgt[2]) * $signed(tag.fwd[1]));
    p[2] <= 32'($signed(rgt[2]) * $signed(tag.fwd[0]));
    p[3] <= 32'($signed(rgt[0]) * $signed(tag.fwd[2]));
    p[4] <= 32'($signed(rgt[0]) * $signed(tag.fwd[1]));
    p[5] <= 32'($signed(rgt[1]) * $signed(tag.fwd[0]));
  end

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] dz;

  always_comb begin
    dx = $signed({p[0][31], p[0]}) - $signed({p[1][31], p[1]});
    dy = $signed({p[2][31], p[2]}) - $signed({p[3][31], p[3]});
    dz = $signed({p[4][31], p[4]}) - $signed({p[5][31], p[5]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    result.fwd_x             <= tag1.fwd[0];
    result.fwd_y             <= tag1.fwd[1];
    result.fwd_z             <= tag1.fwd[2];
    result.rgt_x             <= r1[0];
    result.rgt_y             <= r1[1];
    result.rgt_z             <= r1[2];
    result.upv_x             <= sat16(34'(dx >>> 14));
    result.upv_y             <= sat16(34'(dy >>> 14));
    result.upv_z             <= sat16(34'(dz >>> 14));
    result.forward_fell_back <= tag1.ffb;
    result.right_fell_back   <= rfb1;
    result.used_x_axis       <= tag1.usedx;
  end

endmodule
`default_nettype wire

[design/orthonormal_frame_builder_unit.sv]
`default_nettype none
// Builds a right-handed orthonormal frame (forward, right, up in Q2.14) from one
// Q16.16 forward vector. A new vector is taken on every cycle that start is high;
// busy never rises. Each transfer gives one result on done, and results leave in
// the order the vectors came. The path runs through two normalize pipelines in
// series, each with 32 square-root stages and RECIP_ITERATIONS + 1 reciprocal
// stages. Write the configuration registers only while no vector is in flight.
module orthonormal_frame_builder_unit
  import ofb_pkg::*;
#(
  parameter int RECIP_ITERATIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ofb_in_t               dir,
  output logic                  done,
  output ofb_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] fb_x;
  logic [15:0] fb_y;
  logic [15:0] fb_z;
  logic [15:0] zero_thr;
  logic [28:0] par_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_x     <= FALLBACK_X_RST;
      fb_y     <= FALLBACK_Y_RST;
      fb_z     <= FALLBACK_Z_RST;
      zero_thr <= ZERO_THR_RST;
      par_thr  <= PARALLEL_THR_RST;
    end else if (cfg_we) begin
      case (ofb_cfg_idx_t'(cfg_idx))
        CFG_FALLBACK_X:   fb_x     <= cfg_data[15:0];
        CFG_FALLBACK_Y:   fb_y     <= cfg_data[15:0];
        CFG_FALLBACK_Z:   fb_z     <= cfg_data[15:0];
        CFG_ZERO_THR:     zero_thr <= cfg_data[15:0];
        CFG_PARALLEL_THR: par_thr  <= cfg_data[28:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  ofb_vec32_t dir_vec;
  ofb_vec16_t fb_vec;
  logic       fwd_valid;
  ofb_vec16_t fwd_vec;
  logic       fwd_fb;
  logic       rq_valid;
  ofb_vec32_t rq_vec;
  ofb_tag_t   rq_tag;
  logic       rgt_valid;
  ofb_vec16_t rgt_vec;
  logic       rgt_fb;
  ofb_tag_t   rgt_tag;

  assign dir_vec = {dir.dir_z, dir.dir_y, dir.dir_x};
  assign fb_vec  = {fb_z, fb_y, fb_x};

  ofb_norm #(
    .RECIP_ITERATIONS(RECIP_ITERATIONS),
    .TAG_W(1)
  ) u_norm_fwd (
    .clk(clk),
    .rst(rst),
    .in_valid(start && !busy),
    .in_vec(dir_vec),
    .in_tag(1'b0),
    .fallback(fb_vec),
    .zero_thr(zero_thr),
    .out_valid(fwd_valid),
    .out_vec(fwd_vec),
    .out_fb(fwd_fb),
    .out_tag()
  );

  ofb_rgt u_rgt (
    .clk(clk),
    .rst(rst),
    .in_valid(fwd_valid),
    .fwd(fwd_vec),
    .ffb(fwd_fb),
    .par_thr(par_thr),
    .out_valid(rq_valid),
    .rq(rq_vec),
    .out_tag(rq_tag)
  );

  ofb_norm #(
    .RECIP_ITERATIONS(RECIP_ITERATIONS),
    .TAG_W($bits(ofb_tag_t))
  ) u_norm_rgt (
    .clk(clk),
    .rst(rst),
    .in_valid(rq_valid),
    .in_vec(rq_vec),
    .in_tag(rq_tag),
    .fallback(fb_vec),
    .zero_thr(zero_thr),
    .out_valid(rgt_valid),
    .out_vec(rgt_vec),
    .out_fb(rgt_fb),
    .out_tag(rgt_tag)
  );

  ofb_upv u_upv (
    .clk(clk),
    .rst(rst),
    .in_valid(rgt_valid),
    .rgt(rgt_vec),
    .rfb(rgt_fb),
    .tag(rgt_tag),
    .done(done),
    .result(result)
  );

  a_rgt_z_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.used_x_axis && !result.right_fell_back |-> result.rgt_z == 16'sd0)
    else $error("right z nonzero on the Z-up path");

  a_rgt_x_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.used_x_axis && !result.right_fell_back |-> result.rgt_x == 16'sd0)
    else $error("right x nonzero on the X-axis path");

  a_fwd_unit: assert property (@(posedge clk) disable iff (rst)
    done && !result.forward_fell_back |->
      result.fwd_x <= 16'sd16384 && result.fwd_x >= -16'sd16384 &&
      result.fwd_y <= 16'sd16384 && result.fwd_y >= -16'sd16384 &&
      result.fwd_z <= 16'sd16384 && result.fwd_z >= -16'sd16384)
    else $error("normalized forward component beyond one");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
  import ofb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECIP_IT = 16;
  localparam int LATENCY = 94 + 2 * RECIP_IT;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  ofb_in_t dir;
  logic done;
  ofb_out_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  orthonormal_frame_builder_unit #(.RECIP_ITERATIONS(RECIP_IT)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .dir(dir), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  logic signed [15:0] fb_x, fb_y, fb_z;
  logic [15:0] zero_thr;
  logic [28:0] par_thr;

  ofb_out_t frame_queue[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;

  typedef struct {
    ofb_in_t v;
    bit has_exp;
    ofb_out_t exp;
  } dir_row_t;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, res, bt;
    rem = v;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt >>= 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input longint c[3], output longint o[3]);
    longint unsigned mag[3], sumsq, len, m, q, r;
    int s;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      sumsq += mag[i] * mag[i];
    end
    len = int_sqrt(sumsq);
    if (len == 0 || len < zero_thr) begin
      o[0] = fb_x;
      o[1] = fb_y;
      o[2] = fb_z;
      return 1;
    end
    m = len;
    s = 0;
    while (m < 64'h8000_0000) begin
      m <<= 1;
      s++;
    end
    q = (64'd1 << (31 + RECIP_IT)) / m;
    for (int i = 0; i < 3; i++) begin
      r = ((mag[i] << s) * q) >> (17 + RECIP_IT);
      o[i] = clamp16(c[i] < 0 ? -longint'(r) : longint'(r));
    end
    return 0;
  endfunction

  function automatic longint floor_div14(longint v);
    if (v >= 0) return v >>> 14;
    return -((-v + 16383) >>> 14);
  endfunction

  function automatic ofb_out_t build_frame(ofb_in_t v);
    ofb_out_t o;
    longint d[3], f[3], rr[3], rq[3], r[3];
    longint unsigned dot;
    bit usedx;
    d[0] = longint'(v.dir_x);
    d[1] = longint'(v.dir_y);
    d[2] = longint'(v.dir_z);
    o.forward_fell_back = unit_vec(d, f);
    rr[0] = f[1];
    rr[1] = -f[0];
    rr[2] = 0;
    dot = rr[0] * rr[0] + rr[1] * rr[1];
    usedx = dot < par_thr;
    if (usedx) begin
      rr[0] = 0;
      rr[1] = f[2];
      rr[2] = -f[1];
    end
    for (int i = 0; i < 3; i++) rq[i] = rr[i] * 4;
    o.right_fell_back = unit_vec(rq, r);
    o.used_x_axis = usedx;
    o.fwd_x = 16'(f[0]);
    o.fwd_y = 16'(f[1]);
    o.fwd_z = 16'(f[2]);
    o.rgt_x = 16'(r[0]);
    o.rgt_y = 16'(r[1]);
    o.rgt_z = 16'(r[2]);
    o.upv_x = 16'(clamp16(floor_div14(r[1] * f[2] - r[2] * f[1])));
    o.upv_y = 16'(clamp16(floor_div14(r[2] * f[0] - r[0] * f[2])));
    o.upv_z = 16'(clamp16(floor_div14(r[0] * f[1] - r[1] * f[0])));
    return o;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ofb_out_t e;
    if (!rst && done) begin
      if (frame_queue.size() == 0) begin
        $error("result: expected none, actual frame");
        errors++;
      end else begin
        e = frame_queue.pop_front();
        check_field("fwd_x", e.fwd_x, result.fwd_x);
        check_field("fwd_y", e.fwd_y, result.fwd_y);
        check_field("fwd_z", e.fwd_z, result.fwd_z);
        check_field("rgt_x", e.rgt_x, result.rgt_x);
        check_field("rgt_y", e.rgt_y, result.rgt_y);
        check_field("rgt_z", e.rgt_z, result.rgt_z);
        check_field("upv_x", e.upv_x, result.upv_x);
        check_field("upv_y", e.upv_y, result.upv_y);
        check_field("upv_z", e.upv_z, result.upv_z);
        check_field("forward_fell_back", e.forward_fell_back, result.forward_fell_back);
        check_field("right_fell_back", e.right_fell_back, result.right_fell_back);
        check_field("used_x_axis", e.used_x_axis, result.used_x_axis);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(ofb_cfg_idx_t idx, logic [28:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_FALLBACK_X: fb_x = val[15:0];
      CFG_FALLBACK_Y: fb_y = val[15:0];
      CFG_FALLBACK_Z: fb_z = val[15:0];
      CFG_ZERO_THR: zero_thr = val[15:0];
      CFG_PARALLEL_THR: par_thr = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    start <= 0;
    while (frame_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_dir(ofb_in_t v, bit has_exp, ofb_out_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    dir <= v;
    frame_queue.push_back(has_exp ? exp : build_frame(v));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(65536 * 4)) - 65536 * 2);
      2: return 32'($signed($urandom_range(16)) - 8);
      default: return $urandom() >>> $urandom_range(31);
    endcase
  endfunction

  function automatic ofb_out_t fb_frame(logic signed [15:0] fx, fy, fz, rx, ry, rz,
                                        ux, uy, uz, bit ff, rf, ux_used);
    ofb_out_t o;
    o = '{fx, fy, fz, rx, ry, rz, ux, uy, uz, ff, rf, ux_used};
    return o;
  endfunction

  initial begin
    dir_row_t rows[$];
    ofb_in_t v;
    ofb_out_t none;
    int mode;
    none = '0;
    errors = 0;
    send_idle_pct = 0;
    rst = 1;
    start = 0;
    dir = '0;
    cfg_we = 0;
    cfg_idx = CFG_FALLBACK_X;
    cfg_data = '0;
    fb_x = FALLBACK_X_RST;
    fb_y = FALLBACK_Y_RST;
    fb_z = FALLBACK_Z_RST;
    zero_thr = ZERO_THR_RST;
    par_thr = PARALLEL_THR_RST;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.push_back('{'{0, 0, 0}, 1,
                     fb_frame(0, 16384, 0, 16384, 0, 0, 0, 0, 16384, 1, 0, 0)});
    rows.push_back('{'{32'h10000, 0, 0}, 1,
                     fb_frame(16384, 0, 0, 0, -16384, 0, 0, 0, 16384, 0, 0, 0)});
    rows.push_back('{'{0, 0, 32'h10000}, 1,
                     fb_frame(0, 0, 16384, 0, 16384, 0, 16384, 0, 0, 0, 0, 1)});
    rows.push_back('{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 0, none});
    rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000}, 0, none});
    rows.push_back('{'{32'h80000000, 0, 0}, 0, none});
    rows.push_back('{'{32'h7fffffff, 32'h80000000, 0}, 0, none});
    rows.push_back('{'{1, 0, 0}, 0, none});
    rows.push_back('{'{32'hffffffff, 1, 32'hffffffff}, 0, none});
    rows.push_back('{'{0, 0, 32'h80000000}, 0, none});
    rows.push_back('{'{32'h100, 32'h100, 32'h7fff0000}, 0, none});
    rows.push_back('{'{32'h12345, 32'hfffe0000, 32'h30000}, 0, none});
    foreach (rows[i]) send_dir(rows[i].v, rows[i].has_exp, rows[i].exp);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_FALLBACK_X, 29'h7fff);
          write_reg(CFG_FALLBACK_Y, 29'h8000);
          write_reg(CFG_FALLBACK_Z, 29'h7fff);
          write_reg(CFG_ZERO_THR, 29'd0);
          write_reg(CFG_PARALLEL_THR, 29'd0);
        end
        1: begin
          write_reg(CFG_ZERO_THR, 29'hffff);
          write_reg(CFG_PARALLEL_THR, 29'h10000000);
        end
        7: begin
          write_reg(CFG_FALLBACK_X, 29'd0);
          write_reg(CFG_FALLBACK_Y, 29'd0);
          write_reg(CFG_FALLBACK_Z, 29'd0);
          write_reg(CFG_ZERO_THR, 29'd1);
          write_reg(CFG_PARALLEL_THR, 29'd26844);
        end
        default: begin
          write_reg(CFG_FALLBACK_X, 29'($urandom()));
          write_reg(CFG_FALLBACK_Y, 29'($urandom()));
          write_reg(CFG_FALLBACK_Z, 29'($urandom()));
          write_reg(CFG_ZERO_THR, 29'($urandom_range(4096)));
          write_reg(CFG_PARALLEL_THR,
                    29'($urandom_range(29'h1fffffff) >> $urandom_range(12)));
        end
      endcase
      send_idle_pct = (ph % 4 == 1) ? 83 : (ph % 4 == 3) ? 13 : 0;
      if (ph == 0) write_reg(ofb_cfg_idx_t'(3'd7), 29'h1fffffff);
      cfg_we <= 0;
      for (int n = 0; n < 80; n++) begin
        mode = $urandom_range(3);
        v.dir_x = rand_comp(mode);
        v.dir_y = rand_comp(mode);
        v.dir_z = rand_comp(mode);
        if ($urandom_range(9) == 0) begin
          v.dir_x = rand_comp(2);
          v.dir_y = rand_comp(2);
        end
        send_dir(v, 0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
design/ofb_pkg.sv
design/ofb_norm.sv
design/ofb_rgt.sv
design/ofb_upv.sv
design/orthonormal_frame_builder_unit.sv
tb/sv/tb_top.sv
